// ----- hw/rtl/fba_pkg.sv -----
package fba_pkg;

   typedef logic [2:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_FIRST  = 3'd0;
   localparam op_type OP_BEST   = 3'd1;
   localparam op_type OP_WORST  = 3'd2;
   localparam op_type OP_FREE   = 3'd3;
   localparam op_type OP_DEFINE = 3'd4;

   localparam status_type ST_ALLOCATED = 2'd0;
   localparam status_type ST_NO_FIT    = 2'd1;
   localparam status_type ST_DONE      = 2'd2;
   localparam status_type ST_IGNORED   = 2'd3;

endpackage

// ----- hw/rtl/fit_block_allocator.sv -----
// A fit reads n = min(blocks_in_use, NUM_BLOCKS) entries, one a cycle, then writes the entry
// that it claims, if any, and registers its result; a fit that finds none skips the write.
// Free reads and then writes back its entry and define writes its entry; a fit with n = 0, an
// ignored free or define and unknown ops go straight to the result. One request is in flight at a time.
// Reset is synchronous; the table RAM is then cleared entry by entry with req_stall high,
// and blocks_in_use returns to 1.
module fit_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fba_pkg::op_type      req_operation,
   input  logic [15:0]          req_request_size,
   input  logic [3:0]           req_block_index,
   input  logic [15:0]          req_block_size,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fba_pkg::status_type  rsp_status,
   output logic [3:0]           rsp_granted_index,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   import fba_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int DW = SIZE_BITS + 1;

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd3;
   localparam logic [2:0] S_FREE_WB = 3'd4;
   localparam logic [2:0] S_WRITE   = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0]           state_ff, state_in;
   op_type               op_ff, op_in;
   logic [SIZE_BITS-1:0] need_ff, need_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [4:0]           biu_ff, biu_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        chosen_ff, chosen_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic [SIZE_BITS-1:0] csize_ff, csize_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic [DW-1:0]        wr_data_ff, wr_data_in;
   status_type           st_ff, st_in;
   logic [3:0]           grant_ff, grant_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_grant_ff, rsp_grant_in;

   logic [CW-1:0]        count_eff;
   logic                 scan_issue;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [DW-1:0]        ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [DW-1:0]        ram_rdata;
   logic                 pick_take;
   logic [SIZE_BITS-1:0] pick_left;
   logic                 accept;
   logic                 csr_write;

   assign count_eff = (32'(biu_ff) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(biu_ff);
   assign scan_issue = (scan_ff != count_eff);
   assign accept = req_valid && !req_stall;
   assign csr_write = psel && penable && pwrite && !paddr[2];

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_index = rsp_grant_ff;
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(biu_ff);

   fba_ram #(
      .WIDTH(DW),
      .DEPTH(NUM_BLOCKS)
   ) u_table (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   fba_pick #(
      .SIZE_BITS(SIZE_BITS)
   ) u_pick (
      .mode(op_ff),
      .need(need_ff),
      .entry_size(ram_rdata[SIZE_BITS-1:0]),
      .entry_taken(ram_rdata[SIZE_BITS]),
      .found(found_ff),
      .best_left(left_ff),
      .take(pick_take),
      .left(pick_left)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      need_in       = need_ff;
      idx_in        = idx_ff;
      biu_in        = csr_write ? pwdata[4:0] : biu_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      left_in       = left_ff;
      csize_in      = csize_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      st_in         = st_ff;
      grant_in      = grant_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_addr_ff;
      ram_wdata     = wr_data_ff;
      ram_re        = 1'b0;
      ram_raddr     = scan_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[AW-1:0];
            ram_wdata = '0;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == CW'(NUM_BLOCKS - 1)) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               need_in  = SIZE_BITS'(32'(req_request_size));
               idx_in   = AW'(req_block_index);
               grant_in = 4'd0;
               unique case (req_operation) inside
                  OP_FIRST, OP_BEST, OP_WORST: begin
                     if (count_eff == '0) begin
                        st_in    = ST_NO_FIT;
                        state_in = S_FINISH;
                     end else begin
                        scan_in  = '0;
                        found_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (32'(req_block_index) < 32'(count_eff)) begin
                        st_in    = ST_DONE;
                        state_in = S_FREE_RD;
                     end else begin
                        st_in    = ST_IGNORED;
                        state_in = S_FINISH;
                     end
                  end
                  OP_DEFINE: begin
                     if (32'(req_block_index) < NUM_BLOCKS) begin
                        wr_addr_in = AW'(req_block_index);
                        wr_data_in = {1'b0, SIZE_BITS'(32'(req_block_size))};
                        st_in      = ST_DONE;
                        state_in   = S_WRITE;
                     end else begin
                        st_in    = ST_IGNORED;
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     st_in    = ST_IGNORED;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_issue) begin
               ram_re    = 1'b1;
               ram_raddr = scan_ff[AW-1:0];
               rd_idx_in = scan_ff[AW-1:0];
               pend_in   = 1'b1;
               scan_in   = scan_ff + 1'b1;
            end
            if (pend_ff && pick_take) begin
               found_in  = 1'b1;
               chosen_in = rd_idx_ff;
               left_in   = pick_left;
               csize_in  = ram_rdata[SIZE_BITS-1:0];
            end
            if (!scan_issue) begin
               if (found_in) begin
                  wr_addr_in = chosen_in;
                  wr_data_in = {1'b1, csize_in};
                  st_in      = ST_ALLOCATED;
                  grant_in   = 4'(32'(chosen_in));
                  state_in   = S_WRITE;
               end else begin
                  st_in    = ST_NO_FIT;
                  state_in = S_FINISH;
               end
            end
         end
         S_FREE_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff;
            state_in  = S_FREE_WB;
         end
         S_FREE_WB: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = {1'b0, ram_rdata[SIZE_BITS-1:0]};
            state_in  = S_FINISH;
         end
         S_WRITE: begin
            ram_we   = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_grant_in  = grant_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         biu_ff       <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         biu_ff       <= biu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      need_ff       <= need_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      chosen_ff     <= chosen_in;
      left_ff       <= left_in;
      csize_ff      <= csize_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      st_ff         <= st_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("table RAM read and written in the same cycle");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_ALLOCATED)) |-> (rsp_granted_index == 4'd0))
      else $error("granted index set on a request that claimed no block");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= count_eff))
      else $error("scan address ran past the active count");

   a_scan_drain: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && !scan_issue) |-> pend_ff)
      else $error("scan ended without a last entry to evaluate");

endmodule

// ----- hw/rtl/fba_ram.sv -----
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/fba_pick.sv -----
module fba_pick #(
   parameter int SIZE_BITS = 16
) (
   input  fba_pkg::op_type        mode,
   input  logic [SIZE_BITS-1:0]   need,
   input  logic [SIZE_BITS-1:0]   entry_size,
   input  logic                   entry_taken,
   input  logic                   found,
   input  logic [SIZE_BITS-1:0]   best_left,
   output logic                   take,
   output logic [SIZE_BITS-1:0]   left
);

   import fba_pkg::*;

   logic fits;
   logic better;

   always_comb begin
      fits   = !entry_taken && (entry_size >= need);
      left   = entry_size - need;
      better = ((mode == OP_BEST) && (left < best_left)) ||
               ((mode == OP_WORST) && (left > best_left));
      take   = fits && (!found || better);
   end

endmodule
